### hdl/fir32_pkg.sv
// Shared types, sizes and constants of the 32-tap saturating FIR filter.
`timescale 1ns / 1ps

package fir32_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int TAP_COUNT    = 32;
   localparam int LANE_COUNT   = 8;
   localparam int OUT_SHIFT    = 14;

   localparam int HIST_DEPTH   = 31;
   localparam int IN_FIELDS    = 8;
   localparam int REG_COUNT    = 8;
   localparam int REG_W        = 64;
   localparam int TAPS_PER_REG = REG_W / SAMPLE_W;
   localparam int CSR_INDEX_W  = $clog2(REG_COUNT);
   localparam int WIN_DEPTH    = HIST_DEPTH + LANE_COUNT;

   localparam int PROD_W       = 2 * SAMPLE_W;
   localparam int GROUP_SIZE   = 4;
   localparam int GROUP_COUNT  = (TAP_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PART_W       = PROD_W + $clog2(GROUP_SIZE);
   localparam int ACC_W        = PROD_W + $clog2(TAP_COUNT);
   localparam int SHIFT_W      = ACC_W - OUT_SHIFT;

   localparam int SAT_MAX      = 32767;
   localparam int SAT_MIN      = -32768;

   typedef logic signed [SAMPLE_W-1:0] fir32_sample_type;
   typedef logic signed [PROD_W-1:0]   fir32_prod_type;
   typedef logic signed [PART_W-1:0]   fir32_part_type;
   typedef logic signed [ACC_W-1:0]    fir32_acc_type;
   typedef logic signed [SHIFT_W-1:0]  fir32_shift_type;
   typedef logic [REG_W-1:0]           fir32_reg_type;

   typedef struct packed {
      logic prod_en;
      logic part_en;
      logic sum_en;
   } fir32_stage_en_type;

endpackage

### hdl/fir_32tap_q14_saturating_core.sv
// Top level of the 32-tap Q14 saturating FIR filter with eight parallel lanes.
`timescale 1ns / 1ps

// Usage:
// Each req item carries eight consecutive 16-bit samples, oldest in
// req_sample_in_0. The rsp item gives one filtered sample per lane: the sum of
// that lane's sample and the 31 before it times the Q14 taps, shifted right by
// 14 with floor and saturated to int16.
// Taps are loaded through the csr port, four taps per 64-bit register; write
// them only while no item is in flight.
// The block is a five-stage pipeline (window, products, partial sums, lane
// sums, saturation/output register) and takes one item every cycle while
// req_stall is low; each item passes through the stages in that order.
// Every stage has its own valid bit, so empty stages keep filling while a
// stalled result waits in the output register; req_stall rises only once all
// five stages hold items behind a stalled rsp channel.
// Reset clears the valid bits, the sample history and the tap registers.

module fir_32tap_q14_saturating_core import fir32_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fir32_sample_type       req_sample_in_0,
   input  fir32_sample_type       req_sample_in_1,
   input  fir32_sample_type       req_sample_in_2,
   input  fir32_sample_type       req_sample_in_3,
   input  fir32_sample_type       req_sample_in_4,
   input  fir32_sample_type       req_sample_in_5,
   input  fir32_sample_type       req_sample_in_6,
   input  fir32_sample_type       req_sample_in_7,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fir32_sample_type       rsp_filtered_0,
   output fir32_sample_type       rsp_filtered_1,
   output fir32_sample_type       rsp_filtered_2,
   output fir32_sample_type       rsp_filtered_3,
   output fir32_sample_type       rsp_filtered_4,
   output fir32_sample_type       rsp_filtered_5,
   output fir32_sample_type       rsp_filtered_6,
   output fir32_sample_type       rsp_filtered_7,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  fir32_reg_type          csr_data
);

   fir32_sample_type   req_sample [IN_FIELDS];
   fir32_sample_type   filtered [IN_FIELDS];
   fir32_reg_type      tap_regs_ff [REG_COUNT];
   fir32_sample_type   taps [TAP_COUNT];
   fir32_sample_type   hist_ff [HIST_DEPTH];
   fir32_sample_type   hist_in [HIST_DEPTH];
   fir32_sample_type   win_ff [WIN_DEPTH];
   fir32_sample_type   win_in [WIN_DEPTH];
   fir32_acc_type      lane_sum [LANE_COUNT];
   fir32_stage_en_type stage_en;

   logic v_win_ff;
   logic v_prod_ff;
   logic v_part_ff;
   logic v_sum_ff;
   logic rdy_win;
   logic rdy_prod;
   logic rdy_part;
   logic rdy_sum;
   logic merge_ready;
   logic accept;

   assign req_sample[0] = req_sample_in_0;
   assign req_sample[1] = req_sample_in_1;
   assign req_sample[2] = req_sample_in_2;
   assign req_sample[3] = req_sample_in_3;
   assign req_sample[4] = req_sample_in_4;
   assign req_sample[5] = req_sample_in_5;
   assign req_sample[6] = req_sample_in_6;
   assign req_sample[7] = req_sample_in_7;

   // Tap registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < REG_COUNT; r++) begin
            tap_regs_ff[r] <= '0;
         end
      end else if (csr_write_enable) begin
         tap_regs_ff[csr_index] <= csr_data;
      end
   end

   for (genvar k = 0; k < TAP_COUNT; k++) begin : g_taps
      assign taps[k] = tap_regs_ff[k / TAPS_PER_REG]
                                  [(k % TAPS_PER_REG) * SAMPLE_W +: SAMPLE_W];
   end

   // A stage loads when it is empty or its successor moves on.
   assign rdy_sum  = !v_sum_ff  || merge_ready;
   assign rdy_part = !v_part_ff || rdy_sum;
   assign rdy_prod = !v_prod_ff || rdy_part;
   assign rdy_win  = !v_win_ff  || rdy_prod;
   assign req_stall = !rdy_win;
   assign accept    = req_valid && rdy_win;

   assign stage_en.prod_en = rdy_prod && v_win_ff;
   assign stage_en.part_en = rdy_part && v_prod_ff;
   assign stage_en.sum_en  = rdy_sum  && v_part_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_win_ff  <= 1'b0;
         v_prod_ff <= 1'b0;
         v_part_ff <= 1'b0;
         v_sum_ff  <= 1'b0;
      end else begin
         if (rdy_win) begin
            v_win_ff <= req_valid;
         end
         if (rdy_prod) begin
            v_prod_ff <= v_win_ff;
         end
         if (rdy_part) begin
            v_part_ff <= v_prod_ff;
         end
         if (rdy_sum) begin
            v_sum_ff <= v_part_ff;
         end
      end
   end

   // The window is the stored history followed by the item's new samples.
   always_comb begin
      for (int j = 0; j < HIST_DEPTH; j++) begin
         win_in[j] = hist_ff[j];
      end
      for (int j = 0; j < LANE_COUNT; j++) begin
         win_in[HIST_DEPTH + j] = req_sample[j];
      end
      for (int j = 0; j < HIST_DEPTH; j++) begin
         hist_in[j] = win_in[j + LANE_COUNT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < HIST_DEPTH; j++) begin
            hist_ff[j] <= '0;
         end
      end else if (accept) begin
         hist_ff <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

   for (genvar j = 0; j < LANE_COUNT; j++) begin : g_lane
      fir32_sample_type lane_samples [TAP_COUNT];

      for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
         assign lane_samples[k] = win_ff[HIST_DEPTH + j - k];
      end

      fir32_lane u_lane (
         .clock    (clock),
         .stage_en (stage_en),
         .samples  (lane_samples),
         .taps     (taps),
         .lane_sum (lane_sum[j])
      );
   end

   fir32_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (v_sum_ff),
      .sum_ready (merge_ready),
      .lane_sum  (lane_sum),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .filtered  (filtered)
   );

   assign rsp_filtered_0 = filtered[0];
   assign rsp_filtered_1 = filtered[1];
   assign rsp_filtered_2 = filtered[2];
   assign rsp_filtered_3 = filtered[3];
   assign rsp_filtered_4 = filtered[4];
   assign rsp_filtered_5 = filtered[5];
   assign rsp_filtered_6 = filtered[6];
   assign rsp_filtered_7 = filtered[7];

`ifndef SYNTHESIS
   a_win_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> v_win_ff)
      else $error("accepted item did not enter the window stage");

   a_hist_shift: assert property (@(posedge clock) disable iff (reset)
      accept |=> hist_ff[HIST_DEPTH-1] == $past(req_sample[LANE_COUNT-1]))
      else $error("history did not take the newest sample of the item");

   a_part_hold: assert property (@(posedge clock) disable iff (reset)
      (v_part_ff && !rdy_part) |=> v_part_ff)
      else $error("blocked partial-sum stage dropped its item");

   a_sum_hold: assert property (@(posedge clock) disable iff (reset)
      (v_sum_ff && !merge_ready) |=> v_sum_ff)
      else $error("blocked lane-sum stage dropped its item");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !v_win_ff && !v_prod_ff && !v_part_ff && !v_sum_ff && !rsp_valid)
      else $error("pipeline not empty after reset");
`endif

endmodule

### hdl/fir32_lane.sv
// One filter lane: tap products, grouped partial sums and the full-width sum.
`timescale 1ns / 1ps

module fir32_lane import fir32_pkg::*; (
   input  logic               clock,
   input  fir32_stage_en_type stage_en,
   input  fir32_sample_type   samples [TAP_COUNT],
   input  fir32_sample_type   taps [TAP_COUNT],
   output fir32_acc_type      lane_sum
);

   fir32_prod_type prod_ff [TAP_COUNT];
   fir32_part_type part_ff [GROUP_COUNT];
   fir32_part_type part_in [GROUP_COUNT];
   fir32_acc_type  sum_ff;
   fir32_acc_type  sum_in;

   always_ff @(posedge clock) begin
      if (stage_en.prod_en) begin
         for (int k = 0; k < TAP_COUNT; k++) begin
            prod_ff[k] <= samples[k] * taps[k];
         end
      end
   end

   always_comb begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         part_in[g] = '0;
         for (int i = 0; i < GROUP_SIZE; i++) begin
            if (g * GROUP_SIZE + i < TAP_COUNT) begin
               part_in[g] = part_in[g] + PART_W'(prod_ff[g * GROUP_SIZE + i]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.part_en) begin
         part_ff <= part_in;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         sum_in = sum_in + ACC_W'(part_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.sum_en) begin
         sum_ff <= sum_in;
      end
   end

   assign lane_sum = sum_ff;

endmodule

### hdl/fir32_merge.sv
// Output stage: scales and saturates every lane sum into the result register.
`timescale 1ns / 1ps

module fir32_merge import fir32_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             sum_valid,
   output logic             sum_ready,
   input  fir32_acc_type    lane_sum [LANE_COUNT],
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fir32_sample_type filtered [IN_FIELDS]
);

   logic             valid_ff;
   fir32_sample_type filtered_ff [IN_FIELDS];
   fir32_sample_type filtered_in [IN_FIELDS];
   fir32_shift_type  shifted [LANE_COUNT];

   assign sum_ready = !valid_ff || !rsp_stall;

   // The arithmetic shift floors toward minus infinity, as the clamp expects.
   always_comb begin
      for (int j = 0; j < IN_FIELDS; j++) begin
         filtered_in[j] = '0;
      end
      for (int j = 0; j < LANE_COUNT; j++) begin
         shifted[j] = SHIFT_W'(lane_sum[j] >>> OUT_SHIFT);
         if (shifted[j] > SAT_MAX) begin
            filtered_in[j] = SAMPLE_W'(SAT_MAX);
         end else if (shifted[j] < SAT_MIN) begin
            filtered_in[j] = SAMPLE_W'(SAT_MIN);
         end else begin
            filtered_in[j] = SAMPLE_W'(shifted[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sum_ready) begin
         valid_ff <= sum_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_ready && sum_valid) begin
         filtered_ff <= filtered_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign filtered  = filtered_ff;

endmodule
